// ===== rtl/core/eia_pkg.sv =====
// ----------------------------------------------------------------------------
// eia_pkg: shared types and constants for the entity id allocator
// Transaction structs, command codes, queue sizing and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package eia_pkg;

    localparam int NUM_IDS = 1024;
    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int CNT_W   = ID_W + 1;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Pool full / id range limit
    localparam cnt_t FULL_CNT = cnt_t'(NUM_IDS);

    // Action codes as they arrive on the request channel
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_FIRST   = 2'd2;
    localparam logic [1:0] ACT_NEXT    = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RELEASE,
        OP_FIRST,
        OP_NEXT
    } op_t;

    typedef struct packed {
        logic [1:0] action;
        id_t        entity_id;
    } req_t;

    typedef struct packed {
        id_t  result_id;
        logic valid_res;
        logic error;
        cnt_t live_count;
    } rsp_t;

    // Classified command passed from front end to back end
    typedef struct packed {
        op_t op;
        id_t id;
    } cmd_t;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic {
        BK_FETCH,
        BK_EXEC
    } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/eia_front.sv =====
// ----------------------------------------------------------------------------
// eia_front: request intake
// Registers an accepted transaction, decodes its action and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module eia_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire eia_pkg::req_t req,
    output logic               push,
    output eia_pkg::cmd_t      cmd,
    input  wire logic          q_full
);
    import eia_pkg::*;

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_reg;
    cmd_t front_next;
    logic accept;
    op_t  op_dec;

    always_comb
    begin
        case (req.action)
            ACT_ALLOC:   op_dec = OP_ALLOC;
            ACT_RELEASE: op_dec = OP_RELEASE;
            ACT_FIRST:   op_dec = OP_FIRST;
            ACT_NEXT:    op_dec = OP_NEXT;
            default:     op_dec = OP_NEXT;
        endcase
    end

    assign req_stall = front_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !q_full;
    assign cmd       = front_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_next       = front_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
            front_next.op    = op_dec;
            front_next.id    = req.entity_id;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/eia_queue.sv =====
// ----------------------------------------------------------------------------
// eia_queue: command queue
// Short FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module eia_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire eia_pkg::cmd_t push_cmd,
    output logic               q_full,
    input  wire logic          pop,
    output logic               q_valid,
    output eia_pkg::cmd_t      head_cmd
);
    import eia_pkg::*;

    cmd_t                 entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg;
    logic [Q_PTR_W:0]     count_next;

    assign q_full   = count_reg == (Q_PTR_W+1)'(Q_DEPTH);
    assign q_valid  = count_reg != '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/eia_back.sv =====
// ----------------------------------------------------------------------------
// eia_back: command execution
// Holds the free stack and link tables; fetch then execute per command.
// ----------------------------------------------------------------------------
`default_nettype none

module eia_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire eia_pkg::cmd_t cmd,
    output logic               pop,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output eia_pkg::rsp_t      rsp
);
    import eia_pkg::*;

    // Memories (no reset; see fill mark below)
    id_t  stack_mem [NUM_IDS];
    id_t  next_mem  [NUM_IDS];
    id_t  prev_mem  [NUM_IDS];
    logic flag_mem  [NUM_IDS];

    id_t  stack_q;
    id_t  next_q;
    id_t  prev_q;
    logic flag_q;

    bk_state_t state_reg;
    bk_state_t state_next;

    cnt_t free_top_reg;
    cnt_t free_top_next;
    // Lowest stack depth ever reached: entries below it are unwritten and stand for
    // their own index, and ids below it have never been allocated.
    cnt_t low_mark_reg;
    cnt_t low_mark_next;
    cnt_t count_reg;
    cnt_t count_next;
    id_t  head_reg;
    id_t  head_next;
    id_t  tail_reg;
    id_t  tail_next;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic commit;
    id_t  pop_idx;
    id_t  alloc_id;
    logic is_live;
    logic is_head;
    logic is_tail;
    logic list_empty;
    logic pool_empty;

    id_t  res_id;
    logic res_valid;
    logic res_err;

    logic stack_we;
    id_t  stack_wa;
    id_t  stack_wd;
    logic next_we;
    id_t  next_wa;
    id_t  next_wd;
    logic prev_we;
    id_t  prev_wa;
    id_t  prev_wd;
    logic flag_we;
    id_t  flag_wa;
    logic flag_wd;

    assign pop_idx    = ID_W'(free_top_reg - 1'b1);
    assign alloc_id   = (free_top_reg == low_mark_reg) ? pop_idx : stack_q;
    assign is_live    = ({1'b0, cmd.id} >= low_mark_reg) && flag_q;
    assign is_head    = cmd.id == head_reg;
    assign is_tail    = cmd.id == tail_reg;
    assign list_empty = count_reg == '0;
    assign pool_empty = free_top_reg == '0;

    // Next state
    always_comb
    begin
        case (state_reg)
            BK_FETCH: state_next = q_valid ? BK_EXEC : BK_FETCH;
            BK_EXEC:  state_next = commit ? BK_FETCH : BK_EXEC;
            default:  state_next = BK_FETCH;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        commit        = (state_reg == BK_EXEC) && (!rsp_valid_reg || !rsp_stall);
        res_id        = '0;
        res_valid     = 1'b0;
        res_err       = 1'b0;
        stack_we      = 1'b0;
        stack_wa      = free_top_reg[ID_W-1:0];
        stack_wd      = cmd.id;
        next_we       = 1'b0;
        next_wa       = tail_reg;
        next_wd       = alloc_id;
        prev_we       = 1'b0;
        prev_wa       = alloc_id;
        prev_wd       = tail_reg;
        flag_we       = 1'b0;
        flag_wa       = alloc_id;
        flag_wd       = 1'b1;
        free_top_next = free_top_reg;
        low_mark_next = low_mark_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;

        case (cmd.op)
            OP_ALLOC:
            begin
                if (!pool_empty)
                begin
                    res_id        = alloc_id;
                    res_valid     = 1'b1;
                    flag_we       = 1'b1;
                    prev_we       = 1'b1;
                    next_we       = !list_empty;
                    if (list_empty)
                    begin
                        head_next = alloc_id;
                    end
                    tail_next     = alloc_id;
                    count_next    = count_reg + 1'b1;
                    free_top_next = free_top_reg - 1'b1;
                    if (free_top_reg == low_mark_reg)
                    begin
                        low_mark_next = free_top_reg - 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (is_live && (free_top_reg < FULL_CNT))
                begin
                    res_id        = cmd.id;
                    res_valid     = 1'b1;
                    // Unlink: predecessor skips forward, successor points back
                    next_we       = !is_head;
                    next_wa       = prev_q;
                    next_wd       = next_q;
                    prev_we       = !is_tail;
                    prev_wa       = next_q;
                    prev_wd       = prev_q;
                    if (is_head)
                    begin
                        head_next = next_q;
                    end
                    if (is_tail)
                    begin
                        tail_next = prev_q;
                    end
                    flag_we       = 1'b1;
                    flag_wa       = cmd.id;
                    flag_wd       = 1'b0;
                    stack_we      = 1'b1;
                    free_top_next = free_top_reg + 1'b1;
                    count_next    = count_reg - 1'b1;
                end
                else
                begin
                    res_err = 1'b1;
                end
            end
            OP_FIRST:
            begin
                if (!list_empty)
                begin
                    res_id    = head_reg;
                    res_valid = 1'b1;
                end
            end
            OP_NEXT:
            begin
                if (!is_live)
                begin
                    res_err = 1'b1;
                end
                else if (!is_tail)
                begin
                    res_id    = next_q;
                    res_valid = 1'b1;
                end
            end
            default:
            begin
                res_err = 1'b0;
            end
        endcase

        if (!commit)
        begin
            stack_we      = 1'b0;
            next_we       = 1'b0;
            prev_we       = 1'b0;
            flag_we       = 1'b0;
            free_top_next = free_top_reg;
            low_mark_next = low_mark_reg;
            count_next    = count_reg;
            head_next     = head_reg;
            tail_next     = tail_reg;
        end

        pop = commit;

        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg && rsp_stall;
        if (commit)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.result_id  = res_id;
            rsp_next.valid_res  = res_valid;
            rsp_next.error      = res_err;
            rsp_next.live_count = count_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            free_top_reg  <= FULL_CNT;
            low_mark_reg  <= FULL_CNT;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_top_reg  <= free_top_next;
            low_mark_reg  <= low_mark_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Memory read ports, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == BK_FETCH)
        begin
            stack_q <= stack_mem[pop_idx];
            next_q  <= next_mem[cmd.id];
            prev_q  <= prev_mem[cmd.id];
            flag_q  <= flag_mem[cmd.id];
        end
    end

    // Memory write ports
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/entity_id_allocator_linked.sv =====
// A request passes the front-end register, the command queue, then back-end fetch and
//   execute states; the back end finishes one transaction before taking the next, with
//   a fetch/execute pair around registered reads of the stack, link and flag memories.
// Reset: asynchronous, active low; ready for transactions once reset is released,
//   with no memory clearing pass.
// ----------------------------------------------------------------------------
// entity_id_allocator_linked: entity id allocator, free stack and live list
// Allocates ids from a LIFO pool, keeps live ids on a doubly linked list in
// allocation order, releases ids and answers first/next queries.
// ----------------------------------------------------------------------------
`default_nettype none

module entity_id_allocator_linked (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire eia_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output eia_pkg::rsp_t      rsp
);
    import eia_pkg::*;

    // Front end to queue
    logic push;
    cmd_t front_cmd;
    logic q_full;

    // Queue to back end
    logic q_valid;
    cmd_t head_cmd;
    logic pop;

    // Front end: registers the transaction and decodes the action code.
    eia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .cmd       (front_cmd),
        .q_full    (q_full)
    );

    // Two-entry queue so intake keeps going while the back end is busy
    // or the response side is stalled.
    eia_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    // Back end: one command at a time. Fetch reads the memories at the
    // command id and the stack top; execute updates links, pool and counts
    // and loads the response register. Ids below the lowest stack depth
    // reached have never been handed out, which stands in for a flag clear
    // and a stack fill after reset.
    eia_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
